### hw/rtl/sorted_max_priority_queue_top_defines.svh
// ----------------------------------------------------------------------------
// sorted max priority queue - assertion macros
// shared assertion forms used by the queue's rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_MAX_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_MAX_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SMPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("smpq assertion failed");

// next-cycle implication, disabled while in reset
`define SMPQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("smpq assertion failed");

`endif

### hw/rtl/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// widths, codes and controller/datapath link types of the priority queue
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int CMD_W    = 1;

    localparam logic [CMD_W-1:0] CMD_ENQ = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the accepted item
        logic rd;     // read the next entry to inspect
        logic step;   // act on the entry read
        logic close;  // scan reached its end
        logic fin;    // commit count and load the result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic rejected;  // empty dequeue or full enqueue
        logic at_end;    // no more entries to visit
        logic shift_on;  // keep scanning after this step
        logic out_free;  // result register can take a new item
    } t_dp_stat;

endpackage

### hw/rtl/smpq_if.sv
// ----------------------------------------------------------------------------
// smpq channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface smpq_req_if;
    logic                                valid;
    logic                                ready;
    logic        [smpq_pkg::CMD_W-1:0]   command;
    logic signed [smpq_pkg::DATA_W-1:0]  value;

    modport source (output valid, command, value, input ready);
    modport sink   (input valid, command, value, output ready);
endinterface

interface smpq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [smpq_pkg::DATA_W-1:0]   result_value;
    logic        [smpq_pkg::STATUS_W-1:0] status;
    logic        [smpq_pkg::COUNT_W-1:0]  element_count;
    logic                                 is_empty;

    modport source (output valid, result_value, status, element_count, is_empty,
                    input ready);
    modport sink   (input valid, result_value, status, element_count, is_empty,
                    output ready);
endinterface

### hw/rtl/sorted_max_priority_queue_top.sv
// enqueue walks down from the tail, moving each smaller entry down one place, m = entries
// moved down; dequeue walks all n stored entries from the head, moving each up one place;
// rejected items go straight to the commit without a scan
// throughput: one item at a time, the next accepted the cycle after its result loads
// a result still held in the output register stalls the commit of the next one
// reset (i_rst_n low, synchronous) empties the queue; the store itself is not cleared
// ----------------------------------------------------------------------------
// sorted_max_priority_queue_top
// max priority queue kept as a descending sorted array in a single-port store
// ----------------------------------------------------------------------------
module sorted_max_priority_queue_top #(
    parameter int CAPACITY = smpq_pkg::CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smpq_req_if.sink   i_req,
    smpq_rsp_if.source o_rsp
);

    smpq_pkg::t_dp_cmd  dp_cmd;
    smpq_pkg::t_dp_stat dp_stat;

    smpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    smpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .o_stat              (dp_stat),
        .i_req_command       (i_req.command),
        .i_req_value         (i_req.value),
        .o_rsp_valid         (o_rsp.valid),
        .i_rsp_ready         (o_rsp.ready),
        .o_rsp_result_value  (o_rsp.result_value),
        .o_rsp_status        (o_rsp.status),
        .o_rsp_element_count (o_rsp.element_count),
        .o_rsp_is_empty      (o_rsp.is_empty)
    );

endmodule

### hw/rtl/smpq_ctrl.sv
// ----------------------------------------------------------------------------
// smpq_ctrl
// sequencer: accepts an item, walks the store one entry at a time, commits
// ----------------------------------------------------------------------------
module smpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  smpq_pkg::t_dp_stat i_stat,
    output smpq_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_STEP  = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.rejected) begin
                    n_state = S_FIN;
                end else if (i_stat.at_end) begin
                    o_cmd.close = 1'b1;
                    n_state     = S_FIN;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = i_stat.shift_on ? S_CHECK : S_FIN;
            end
            S_FIN: begin
                // hold until the result register is free
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/smpq_dp.sv
// ----------------------------------------------------------------------------
// smpq_dp
// entry store, scan index, element count and result register
// ----------------------------------------------------------------------------
`include "sorted_max_priority_queue_top_defines.svh"

module smpq_dp #(
    parameter int CAPACITY = smpq_pkg::CAPACITY
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  smpq_pkg::t_dp_cmd                    i_cmd,
    output smpq_pkg::t_dp_stat                   o_stat,
    input  logic        [smpq_pkg::CMD_W-1:0]    i_req_command,
    input  logic signed [smpq_pkg::DATA_W-1:0]   i_req_value,
    output logic                                 o_rsp_valid,
    input  logic                                 i_rsp_ready,
    output logic signed [smpq_pkg::DATA_W-1:0]   o_rsp_result_value,
    output logic        [smpq_pkg::STATUS_W-1:0] o_rsp_status,
    output logic        [smpq_pkg::COUNT_W-1:0]  o_rsp_element_count,
    output logic                                 o_rsp_is_empty
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [smpq_pkg::DATA_W-1:0] mem [CAPACITY];

    logic        [smpq_pkg::CMD_W-1:0]    r_cmd;
    logic signed [smpq_pkg::DATA_W-1:0]   r_val;
    logic        [smpq_pkg::STATUS_W-1:0] r_status;
    logic        [CW-1:0]                 r_count;
    logic        [CW-1:0]                 r_idx;
    logic signed [smpq_pkg::DATA_W-1:0]   r_rdata;
    logic signed [smpq_pkg::DATA_W-1:0]   r_res;

    logic                                 r_out_valid;
    logic signed [smpq_pkg::DATA_W-1:0]   r_out_value;
    logic        [smpq_pkg::STATUS_W-1:0] r_out_status;
    logic        [smpq_pkg::COUNT_W-1:0]  r_out_count;
    logic                                 r_out_empty;

    logic                               is_deq;
    logic [CW-1:0]                      idx_dec;
    logic [AW-1:0]                      rd_addr;
    logic                               lt;
    logic                               we;
    logic [AW-1:0]                      waddr;
    logic signed [smpq_pkg::DATA_W-1:0] wdata;
    logic [CW-1:0]                      n_count;
    logic [CW+smpq_pkg::COUNT_W-1:0]    count_ext;

    assign is_deq  = (r_cmd == smpq_pkg::CMD_DEQ);
    assign idx_dec = r_idx - 1'b1;
    // dequeue walks upward from the head, enqueue walks down from the tail
    assign rd_addr = is_deq ? r_idx[AW-1:0] : idx_dec[AW-1:0];
    assign lt      = (r_rdata < r_val);

    assign o_stat.rejected = (r_status != smpq_pkg::ST_OK);
    assign o_stat.at_end   = is_deq ? (r_idx == r_count) : (r_idx == '0);
    assign o_stat.shift_on = is_deq ? 1'b1 : lt;
    assign o_stat.out_free = !r_out_valid || i_rsp_ready;

    always_comb begin
        we    = 1'b0;
        waddr = r_idx[AW-1:0];
        wdata = r_val;
        if (i_cmd.step) begin
            if (is_deq) begin
                // head entry goes to the result, others move up one place
                we    = (r_idx != '0);
                waddr = idx_dec[AW-1:0];
                wdata = r_rdata;
            end else begin
                we    = 1'b1;
                wdata = lt ? r_rdata : r_val;
            end
        end else if (i_cmd.close && !is_deq) begin
            we = 1'b1;
        end
    end

    always_comb begin
        n_count = r_count;
        if (r_status == smpq_pkg::ST_OK) begin
            n_count = is_deq ? r_count - 1'b1 : r_count + 1'b1;
        end
    end

    assign count_ext = (CW + smpq_pkg::COUNT_W)'(n_count);

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_req_command;
            r_val  <= i_req_value;
            r_res  <= '0;
            if (i_req_command == smpq_pkg::CMD_DEQ) begin
                r_idx    <= '0;
                r_status <= (r_count == '0) ? smpq_pkg::ST_EMPTY : smpq_pkg::ST_OK;
            end else begin
                r_idx    <= r_count;
                r_status <= (r_count == CW'(CAPACITY)) ? smpq_pkg::ST_FULL
                                                       : smpq_pkg::ST_OK;
            end
        end else if (i_cmd.step) begin
            if (is_deq) begin
                if (r_idx == '0) begin
                    r_res <= r_rdata;
                end
                r_idx <= r_idx + 1'b1;
            end else if (lt) begin
                r_idx <= idx_dec;
            end
        end
        if (i_cmd.fin) begin
            r_out_value  <= r_res;
            r_out_status <= r_status;
            r_out_count  <= count_ext[smpq_pkg::COUNT_W-1:0];
            r_out_empty  <= (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.fin) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid         = r_out_valid;
    assign o_rsp_result_value  = r_out_value;
    assign o_rsp_status        = r_out_status;
    assign o_rsp_element_count = r_out_count;
    assign o_rsp_is_empty      = r_out_empty;

    `SMPQ_ASSERT_NXT(a_enq_grows, i_clk, i_rst_n, i_cmd.fin && !o_stat.rejected && !is_deq, r_count == $past(r_count) + 1'b1)
    `SMPQ_ASSERT_NXT(a_reject_keeps, i_clk, i_rst_n, i_cmd.fin && o_stat.rejected, $stable(r_count))
    `SMPQ_ASSERT_IMP(a_fin_free, i_clk, i_rst_n, i_cmd.fin, !r_out_valid || i_rsp_ready)
    `SMPQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))

endmodule
